>>> hw/rtl/datt_pkg.sv
// Shared types and codes for the deferred action timer table.
package datt_pkg;

   localparam int unsigned DATT_ENTRIES   = 16;
   localparam int unsigned DATT_TIME_BITS = 32;

   localparam logic [1:0] CMD_ADD     = 2'd0;
   localparam logic [1:0] CMD_DELETE  = 2'd1;
   localparam logic [1:0] CMD_PROCESS = 2'd2;

   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_DELETED = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_EXPIRED = 3'd4;
   localparam logic [2:0] ST_NONE    = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_time;
      logic [23:0] delay_ticks;
      logic [15:0] action_id;
      logic [15:0] socket_handle;
      logic [15:0] message_handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_id;
      logic [15:0] out_socket;
      logic [15:0] out_message;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] socket;
      logic [15:0] message;
   } slot_type;

   typedef struct packed {
      logic accept;
      logic add;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       out_free;
      logic       scan_done;
   } dp_stat_type;

endpackage

>>> hw/rtl/datt_ctrl.sv
// Sequencing state machine for the deferred action timer table.
module datt_ctrl
   import datt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_ADD  = 4'b0010,
      S_SCAN = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               case (stat.command)
                  CMD_ADD:                 state_in = S_ADD;
                  CMD_DELETE, CMD_PROCESS: state_in = S_SCAN;
                  default:                 state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (stat.out_free) begin
               cmd.add  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> hw/rtl/datt_dp.sv
// Datapath: slot memory in insertion order, compacting scan and result register.
module datt_dp
   import datt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = DATT_ENTRIES,
   parameter int unsigned TIME_BITS     = DATT_TIME_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

   logic [TIME_BITS-1:0] mem_dl [TABLE_ENTRIES];
   slot_type             mem_pl [TABLE_ENTRIES];

   req_type              req_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rp_ff, rp_in;
   logic [CW-1:0]        wr_ff, wr_in;
   logic                 ev_ff, ev_in;
   logic                 found_ff, found_in;
   logic                 pend_valid_ff, pend_valid_in;
   slot_type             pend_ff, pend_in;
   logic [TIME_BITS-1:0] rd_dl_ff;
   slot_type             rd_pl_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic                 out_free, full, is_proc, expired, drop, stall, step, rd_en;
   logic                 mem_we;
   logic [IW-1:0]        mem_wa;
   logic [TIME_BITS-1:0] mem_wdl;
   slot_type             mem_wpl;
   logic [TIME_BITS-1:0] now_t, diff;

   assign out_free = !out_valid_ff || rsp_ready;
   assign full     = (count_ff == CW'(TABLE_ENTRIES));
   assign is_proc  = (req_ff.command == CMD_PROCESS);
   assign now_t    = TIME_BITS'(req_ff.now_time);
   assign diff     = now_t - rd_dl_ff;
   assign expired  = !diff[TIME_BITS-1];
   assign drop     = is_proc ? expired : ((rd_pl_ff.id == req_ff.action_id) && !found_ff);
   assign stall    = ev_ff && is_proc && expired && pend_valid_ff && !out_free;
   assign step     = cmd.scan && !stall;
   assign rd_en    = step && (rp_ff < count_ff);

   assign stat.command   = req_data.command;
   assign stat.out_free  = out_free;
   assign stat.scan_done = (rp_ff == count_ff) && !ev_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      count_in      = count_ff;
      rp_in         = rp_ff;
      wr_in         = wr_ff;
      ev_in         = ev_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      mem_we        = 1'b0;
      mem_wa        = wr_ff[IW-1:0];
      mem_wdl       = rd_dl_ff;
      mem_wpl       = rd_pl_ff;

      if (cmd.accept) begin
         rp_in         = '0;
         wr_in         = '0;
         ev_in         = 1'b0;
         found_in      = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (cmd.add) begin
         out_valid_in       = 1'b1;
         out_in.status      = full ? ST_FULL : ST_ADDED;
         out_in.out_id      = req_ff.action_id;
         out_in.out_socket  = '0;
         out_in.out_message = '0;
         out_in.last        = 1'b1;
         if (!full) begin
            mem_we         = 1'b1;
            mem_wa         = count_ff[IW-1:0];
            mem_wdl        = now_t + TIME_BITS'(req_ff.delay_ticks);
            mem_wpl.id      = req_ff.action_id;
            mem_wpl.socket  = req_ff.socket_handle;
            mem_wpl.message = req_ff.message_handle;
            count_in       = count_ff + CW'(1);
         end
      end

      if (step) begin
         if (ev_ff) begin
            if (!drop) begin
               mem_we = 1'b1;
               wr_in  = wr_ff + CW'(1);
            end else if (is_proc) begin
               pend_valid_in = 1'b1;
               pend_in       = rd_pl_ff;
               if (pend_valid_ff) begin
                  out_valid_in       = 1'b1;
                  out_in.status      = ST_EXPIRED;
                  out_in.out_id      = pend_ff.id;
                  out_in.out_socket  = pend_ff.socket;
                  out_in.out_message = pend_ff.message;
                  out_in.last        = 1'b0;
               end
            end else begin
               found_in = 1'b1;
            end
         end
         ev_in = rd_en;
         if (rd_en) rp_in = rp_ff + CW'(1);
      end

      if (cmd.finish) begin
         count_in     = wr_ff;
         out_valid_in = 1'b1;
         out_in.last  = 1'b1;
         if (is_proc) begin
            out_in.status      = pend_valid_ff ? ST_EXPIRED : ST_NONE;
            out_in.out_id      = pend_valid_ff ? pend_ff.id : '0;
            out_in.out_socket  = pend_valid_ff ? pend_ff.socket : '0;
            out_in.out_message = pend_valid_ff ? pend_ff.message : '0;
         end else begin
            out_in.status      = found_ff ? ST_DELETED : ST_ABSENT;
            out_in.out_id      = req_ff.action_id;
            out_in.out_socket  = '0;
            out_in.out_message = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_dl[mem_wa] <= mem_wdl;
         mem_pl[mem_wa] <= mem_wpl;
      end
      if (rd_en) begin
         rd_dl_ff <= mem_dl[rp_ff[IW-1:0]];
         rd_pl_ff <= mem_pl[rp_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_data;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rp_ff         <= '0;
         wr_ff         <= '0;
         ev_ff         <= 1'b0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rp_ff         <= rp_in;
         wr_ff         <= wr_in;
         ev_ff         <= ev_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_wr_behind_rp: assert property (@(posedge clock) disable iff (reset)
      (wr_ff <= rp_ff) && (rp_ff <= CW'(TABLE_ENTRIES)))
      else $error("compaction pointer ahead of read pointer");

   a_pend_only_proc: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> is_proc)
      else $error("pending expiry outside a process scan");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("result register overwritten before transfer");

endmodule

>>> hw/rtl/deferred_action_timer_table_unit.sv
// Add: the result is loaded in the add state once the result register is free; then idle.
// Delete and process walk the N live entries once, reading one entry per scan step,
// and load the final result in the finish state once the result register is free;
// the unit then returns to idle and takes the next request.
// Every result, each expired entry after the first included, waits while the result
// register is held. Reset empties the table at once; no clearing pass over the memory.
module deferred_action_timer_table_unit
   import datt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = DATT_ENTRIES,
   parameter int unsigned TIME_BITS     = DATT_TIME_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   datt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   datt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TIME_BITS     (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
